// ===== rtl/wmci_pkg.sv =====
// Shared widths, element types and constants for the warp matrix compose and invert block.
`timescale 1ns / 1ps
package wmci_pkg;

    // Composed matrix element: exact, in units of 2^-(FRAC_BITS+1).
    localparam int C_W    = 36;
    localparam int PROD_W = 2 * C_W;        // 2x2 minor product
    localparam int COF_W  = PROD_W + 1;     // adjugate entry
    localparam int LO_W   = 37;             // low slice of a cofactor for the det products
    localparam int HI_W   = COF_W - LO_W;
    localparam int DET_W  = C_W + COF_W + 2;
    localparam int QB     = 33;             // quotient bits kept before saturation
    localparam int DIV_LAT = QB + 2;
    localparam int COF_LAT = 5;
    // compose + cofactor/det + abs + divider + output register
    localparam int LATENCY = 1 + COF_LAT + 1 + DIV_LAT + 1;

    typedef logic signed [C_W-1:0]   celem_t;
    typedef logic signed [COF_W-1:0] cof_t;
    typedef logic signed [DET_W-1:0] det_t;

    typedef struct packed {
        logic valid;
        logic zero;
    } det_info_t;

endpackage

// ===== rtl/wmci_compose.sv =====
// Stage one: composes the projection with the scale and half-pixel offset step matrix.
`timescale 1ns / 1ps
module wmci_compose
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  valid_in,
    input  logic signed [31:0]    p [9],
    input  logic [2:0]            step_scale,
    input  logic [1:0]            offset_x,
    input  logic [1:0]            offset_y,
    output logic                  valid_out,
    output wmci_pkg::celem_t      c [9]
);

    logic             valid_reg;
    wmci_pkg::celem_t c_reg [9];
    wmci_pkg::celem_t c_next [9];
    wmci_pkg::celem_t sc, hx, hy;
    wmci_pkg::celem_t pe [9];

    always_comb
    begin
        sc = $signed({33'd0, step_scale});
        hx = $signed({33'd0, offset_x, 1'b0}) - 36'sd1;
        hy = $signed({33'd0, offset_y, 1'b0}) - 36'sd1;
        for (int j = 0; j < 9; j++)
        begin
            pe[j] = wmci_pkg::C_W'(p[j]);
        end
        for (int r = 0; r < 3; r++)
        begin
            c_next[3*r]   = (pe[3*r] * sc) <<< 1;
            c_next[3*r+1] = (pe[3*r+1] * sc) <<< 1;
            c_next[3*r+2] = pe[3*r] * hx + pe[3*r+1] * hy + (pe[3*r+2] <<< 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        c_reg <= c_next;
    end

    assign valid_out = valid_reg;
    assign c         = c_reg;

endmodule

// ===== rtl/wmci_cofactor.sv =====
// Adjugate and determinant pipeline: minors, cofactors, split det products, det sum.
`timescale 1ns / 1ps
module wmci_cofactor
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  valid_in,
    input  wmci_pkg::celem_t      c [9],
    output wmci_pkg::det_info_t   info,
    output wmci_pkg::cof_t        cof [9],
    output wmci_pkg::det_t        det
);

    localparam int PLO_W = wmci_pkg::C_W + wmci_pkg::LO_W + 1;
    localparam int PHI_W = wmci_pkg::C_W + wmci_pkg::HI_W;

    // minor operand index pairs: cof[i] = c[a0]*c[b0] - c[a1]*c[b1]
    localparam int A0 [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int B0 [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int A1 [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int B1 [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

    logic [wmci_pkg::COF_LAT-1:0] vld_reg;

    logic signed [wmci_pkg::PROD_W-1:0] pa_reg [9];
    logic signed [wmci_pkg::PROD_W-1:0] pb_reg [9];
    wmci_pkg::celem_t c1_reg [3];
    wmci_pkg::celem_t c2_reg [3];
    wmci_pkg::cof_t   cof2_reg [9];
    wmci_pkg::cof_t   cof3_reg [9];
    wmci_pkg::cof_t   cof4_reg [9];
    wmci_pkg::cof_t   cof5_reg [9];
    logic signed [PLO_W-1:0] plo_reg [3];
    logic signed [PHI_W-1:0] phi_reg [3];
    wmci_pkg::det_t   term_reg [3];
    wmci_pkg::det_t   det_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[wmci_pkg::COF_LAT-2:0], valid_in};
    end

    always_ff @(posedge clk)
    begin
        // minor products
        for (int i = 0; i < 9; i++)
        begin
            pa_reg[i] <= c[A0[i]] * c[B0[i]];
            pb_reg[i] <= c[A1[i]] * c[B1[i]];
        end
        for (int i = 0; i < 3; i++)
        begin
            c1_reg[i] <= c[i];
            c2_reg[i] <= c1_reg[i];
        end
        // cofactors
        for (int i = 0; i < 9; i++)
        begin
            cof2_reg[i] <= wmci_pkg::COF_W'(pa_reg[i]) - wmci_pkg::COF_W'(pb_reg[i]);
            cof3_reg[i] <= cof2_reg[i];
            cof4_reg[i] <= cof3_reg[i];
            cof5_reg[i] <= cof4_reg[i];
        end
        // det = c0*cof0 + c1*cof3 + c2*cof6, each cofactor split in two slices
        for (int i = 0; i < 3; i++)
        begin
            plo_reg[i] <= c2_reg[i] * $signed({1'b0, cof2_reg[3*i][wmci_pkg::LO_W-1:0]});
            phi_reg[i] <= c2_reg[i] *
                          $signed(cof2_reg[3*i][wmci_pkg::COF_W-1:wmci_pkg::LO_W]);
            term_reg[i] <= (wmci_pkg::DET_W'(phi_reg[i]) <<< wmci_pkg::LO_W) +
                           wmci_pkg::DET_W'(plo_reg[i]);
        end
        det_reg <= term_reg[0] + term_reg[1] + term_reg[2];
    end

    assign info.valid = vld_reg[wmci_pkg::COF_LAT-1];
    assign info.zero  = (det_reg == '0);
    assign cof        = cof5_reg;
    assign det        = det_reg;

endmodule

// ===== rtl/wmci_divider.sv =====
// One lane of the restoring divider: rounded, saturated cofactor over determinant.
`timescale 1ns / 1ps
module wmci_divider #(
    parameter int FRAC_BITS = 16
)
(
    input  logic                          clk,
    input  logic [wmci_pkg::COF_W-1:0]    num_abs,
    input  logic [wmci_pkg::DET_W-1:0]    den_abs,
    input  logic                          neg,
    output logic signed [31:0]            result
);

    localparam int QB    = wmci_pkg::QB;
    localparam int NUM_W = wmci_pkg::COF_W + 2 * FRAC_BITS + 3;
    localparam int SH_W  = wmci_pkg::DET_W + 1 + QB;
    localparam int W     = ((NUM_W > SH_W) ? NUM_W : SH_W) + 1;
    localparam logic [QB-1:0] LIM_POS = QB'(64'h7FFF_FFFF);
    localparam logic [QB-1:0] LIM_NEG = QB'(64'h8000_0000);

    logic [W-1:0]  num_full, dv_full;
    logic [W-1:0]  rem_reg [QB];
    logic [W-1:0]  dv_reg  [QB];
    logic [QB-1:0] q_reg   [QB+1];
    logic          neg_reg [QB+1];
    logic          ovf_reg [QB+1];
    logic [QB-1:0] lim, mag;
    logic signed [31:0] result_reg;

    // floor((2*n*2^(2F+1) + d) / (2*d)) rounds n*2^(2F+1)/d half away from zero
    assign num_full = (W'(num_abs) << (2 * FRAC_BITS + 2)) + W'(den_abs);
    assign dv_full  = W'(den_abs) << 1;

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= num_full;
        dv_reg[0]  <= dv_full;
        q_reg[0]   <= '0;
        neg_reg[0] <= neg;
        ovf_reg[0] <= (num_full >= (dv_full << QB));
    end

    for (genvar k = 0; k < QB; k++)
    begin : g_stage
        logic [W:0] diff;
        assign diff = {1'b0, rem_reg[k]} - {1'b0, dv_reg[k] << (QB - 1 - k)};

        always_ff @(posedge clk)
        begin
            q_reg[k+1]   <= {q_reg[k][QB-2:0], ~diff[W]};
            neg_reg[k+1] <= neg_reg[k];
            ovf_reg[k+1] <= ovf_reg[k];
        end

        if (k < QB - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[k+1] <= diff[W] ? rem_reg[k] : diff[W-1:0];
                dv_reg[k+1]  <= dv_reg[k];
            end
        end
    end

    always_comb
    begin
        lim = neg_reg[QB] ? LIM_NEG : LIM_POS;
        mag = (ovf_reg[QB] || (q_reg[QB] > lim)) ? lim : q_reg[QB];
    end

    always_ff @(posedge clk)
    begin
        result_reg <= neg_reg[QB] ? -$signed(mag[31:0]) : $signed(mag[31:0]);
    end

    assign result = result_reg;

endmodule

// ===== rtl/warp_matrix_compose_invert.sv =====
// Top level: composes a projection with a step matrix and returns its saturated inverse.
`timescale 1ns / 1ps
// Usage
//   Command channel: a word is taken at each rising edge where start is high and
//   busy is low. busy is held low: the pipeline takes one word every cycle.
//   Payload: nine Q16.16 projection elements (row major), step_scale, offset_x,
//   offset_y.
//   Result channel: done pulses for one cycle with inv_r*c* and singular valid in
//   that cycle. Results leave in the order the words came in. The receiver cannot
//   hold results off and the block never needs it to.
//   Path: a word passes the compose, cofactor/determinant, magnitude, divider and
//   output registers in that order; done and the results come from the last.
//   Throughput: one word per cycle. The determinant divide is a 33-stage restoring
//   divider, one quotient bit per stage, nine lanes sharing a pipelined
//   determinant; its length sets the latency.
//   A zero determinant gives singular = 1 and all nine elements zero.
//   Reset clears every valid bit, so no done pulse comes out of words in flight;
//   payload registers are not reset.
module warp_matrix_compose_invert #(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] proj_r0c0,
    input  logic signed [31:0] proj_r0c1,
    input  logic signed [31:0] proj_r0c2,
    input  logic signed [31:0] proj_r1c0,
    input  logic signed [31:0] proj_r1c1,
    input  logic signed [31:0] proj_r1c2,
    input  logic signed [31:0] proj_r2c0,
    input  logic signed [31:0] proj_r2c1,
    input  logic signed [31:0] proj_r2c2,
    input  logic [2:0]         step_scale,
    input  logic [1:0]         offset_x,
    input  logic [1:0]         offset_y,
    output logic               done,
    output logic signed [31:0] inv_r0c0,
    output logic signed [31:0] inv_r0c1,
    output logic signed [31:0] inv_r0c2,
    output logic signed [31:0] inv_r1c0,
    output logic signed [31:0] inv_r1c1,
    output logic signed [31:0] inv_r1c2,
    output logic signed [31:0] inv_r2c0,
    output logic signed [31:0] inv_r2c1,
    output logic signed [31:0] inv_r2c2,
    output logic               singular
);

    localparam int DL = wmci_pkg::DIV_LAT;

    logic signed [31:0]  p [9];
    logic                c_valid;
    wmci_pkg::celem_t    c [9];
    wmci_pkg::det_info_t info;
    wmci_pkg::cof_t      cof [9];
    wmci_pkg::det_t      det;

    // magnitude stage
    logic                       vld_a_reg, zero_a_reg;
    logic [wmci_pkg::COF_W-1:0] num_a_reg [9];
    logic [wmci_pkg::DET_W-1:0] den_a_reg;
    logic                       neg_a_reg [9];

    logic [DL-1:0]      vld_pipe_reg, sing_pipe_reg;
    logic signed [31:0] quo [9];

    logic               done_reg, singular_reg;
    logic signed [31:0] inv_reg [9];

    assign busy = 1'b0;

    assign p = '{proj_r0c0, proj_r0c1, proj_r0c2,
                 proj_r1c0, proj_r1c1, proj_r1c2,
                 proj_r2c0, proj_r2c1, proj_r2c2};

    wmci_compose u_compose
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid_in   (start && !busy),
        .p          (p),
        .step_scale (step_scale),
        .offset_x   (offset_x),
        .offset_y   (offset_y),
        .valid_out  (c_valid),
        .c          (c)
    );

    wmci_cofactor u_cofactor
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid_in (c_valid),
        .c        (c),
        .info     (info),
        .cof      (cof),
        .det      (det)
    );

    // signs split off so the divider works on magnitudes
    always_ff @(posedge clk)
    begin
        den_a_reg <= det[wmci_pkg::DET_W-1] ? wmci_pkg::DET_W'(-det) : wmci_pkg::DET_W'(det);
        for (int i = 0; i < 9; i++)
        begin
            num_a_reg[i] <= cof[i][wmci_pkg::COF_W-1] ? wmci_pkg::COF_W'(-cof[i])
                                                      : wmci_pkg::COF_W'(cof[i]);
            neg_a_reg[i] <= cof[i][wmci_pkg::COF_W-1] ^ det[wmci_pkg::DET_W-1];
        end
        zero_a_reg    <= info.zero;
        sing_pipe_reg <= {sing_pipe_reg[DL-2:0], zero_a_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg    <= 1'b0;
            vld_pipe_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            vld_a_reg    <= info.valid;
            vld_pipe_reg <= {vld_pipe_reg[DL-2:0], vld_a_reg};
            done_reg     <= vld_pipe_reg[DL-1];
        end
    end

    for (genvar i = 0; i < 9; i++)
    begin : g_lane
        wmci_divider #(.FRAC_BITS(FRAC_BITS)) u_div
        (
            .clk     (clk),
            .num_abs (num_a_reg[i]),
            .den_abs (den_a_reg),
            .neg     (neg_a_reg[i]),
            .result  (quo[i])
        );
    end

    // a singular word reports all-zero elements
    always_ff @(posedge clk)
    begin
        singular_reg <= sing_pipe_reg[DL-1];
        for (int i = 0; i < 9; i++)
        begin
            inv_reg[i] <= sing_pipe_reg[DL-1] ? 32'sd0 : quo[i];
        end
    end

    assign done     = done_reg;
    assign singular = singular_reg;
    assign inv_r0c0 = inv_reg[0];
    assign inv_r0c1 = inv_reg[1];
    assign inv_r0c2 = inv_reg[2];
    assign inv_r1c0 = inv_reg[3];
    assign inv_r1c1 = inv_reg[4];
    assign inv_r1c2 = inv_reg[5];
    assign inv_r2c0 = inv_reg[6];
    assign inv_r2c1 = inv_reg[7];
    assign inv_r2c2 = inv_reg[8];

endmodule

// ===== rtl/wmci_checker.sv =====
// Port-level checks on the compose and invert block, bound to the top level.
`timescale 1ns / 1ps
module wmci_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic               singular,
    input logic signed [31:0] inv_r0c0,
    input logic signed [31:0] inv_r0c1,
    input logic signed [31:0] inv_r0c2,
    input logic signed [31:0] inv_r1c0,
    input logic signed [31:0] inv_r1c1,
    input logic signed [31:0] inv_r1c2,
    input logic signed [31:0] inv_r2c0,
    input logic signed [31:0] inv_r2c1,
    input logic signed [31:0] inv_r2c2
);

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_word_out: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(wmci_pkg::LATENCY) done)
        else $error("accepted word produced no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, wmci_pkg::LATENCY))
        else $error("result without a matching word");

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && singular) |-> (inv_r0c0 == 0 && inv_r0c1 == 0 && inv_r0c2 == 0 &&
                                inv_r1c0 == 0 && inv_r1c1 == 0 && inv_r1c2 == 0 &&
                                inv_r2c0 == 0 && inv_r2c1 == 0 && inv_r2c2 == 0))
        else $error("singular result with nonzero elements");

endmodule

bind warp_matrix_compose_invert wmci_checker u_wmci_checker (.*);
